// ----- design/bmrk_pkg.sv -----
// Shared types, constants, saturating helpers and the microcode program
// for the bend multipole radiation kick unit. No dependencies.
package bmrk_pkg;

  localparam int CW       = 48;   // coordinate width
  localparam int FRAC     = 40;
  localparam int RC_FRAC  = 60;
  localparam int ODEPTH   = 16;
  localparam int OIDX_W   = $clog2(ODEPTH);
  localparam int PC_W     = 7;
  localparam int RA_W     = 5;
  localparam int DIV_STEPS  = 64 + FRAC;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_ORDER = 2'd0;
  localparam logic [1:0] CFG_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_IRHO      = 2'd2;
  localparam logic [1:0] CFG_RAD       = 2'd3;

  // opcodes
  localparam logic [4:0] OP_LDIN  = 5'd0;
  localparam logic [4:0] OP_LDCN  = 5'd1;
  localparam logic [4:0] OP_LDCS  = 5'd2;
  localparam logic [4:0] OP_ADD   = 5'd3;
  localparam logic [4:0] OP_SUB   = 5'd4;
  localparam logic [4:0] OP_MOV   = 5'd5;
  localparam logic [4:0] OP_SHR   = 5'd6;
  localparam logic [4:0] OP_MUL   = 5'd7;
  localparam logic [4:0] OP_MULRC = 5'd8;
  localparam logic [4:0] OP_DIV   = 5'd9;
  localparam logic [4:0] OP_STO   = 5'd10;
  localparam logic [4:0] OP_SETC  = 5'd11;
  localparam logic [4:0] OP_BRZ   = 5'd12;
  localparam logic [4:0] OP_DEC   = 5'd13;
  localparam logic [4:0] OP_JMP   = 5'd14;
  localparam logic [4:0] OP_WOUT  = 5'd15;
  localparam logic [4:0] OP_END   = 5'd16;

  // register file addresses; the first ten double as input source codes
  localparam logic [RA_W-1:0] R_X = 5'd0,  R_PX = 5'd1,  R_Y = 5'd2,  R_PY = 5'd3;
  localparam logic [RA_W-1:0] R_DP = 5'd4, R_Z = 5'd5,   R_L = 5'd6,  R_IRHO = 5'd7;
  localparam logic [RA_W-1:0] R_RC = 5'd8, R_ONE = 5'd9, R_RE = 5'd10, R_IM = 5'd11;
  localparam logic [RA_W-1:0] R_T0 = 5'd12, R_T1 = 5'd13, R_T2 = 5'd14, R_T3 = 5'd15;
  localparam logic [RA_W-1:0] R_OPD = 5'd16, R_XPR = 5'd17, R_YPR = 5'd18, R_XR = 5'd19;
  localparam logic [RA_W-1:0] R_H = 5'd20, R_BY = 5'd21, R_ANG2 = 5'd22, R_DEN = 5'd23;
  localparam logic [RA_W-1:0] R_NUM = 5'd24, R_B2P = 5'd25, R_FAC = 5'd26, R_LOSS = 5'd27;
  localparam logic [RA_W-1:0] R_DPN = 5'd28, R_OPDN = 5'd29, R_PXN = 5'd30, R_PYN = 5'd31;

  // result field codes for OP_STO
  localparam logic [RA_W-1:0] F_POS_X = 5'd0, F_MOM_X = 5'd1, F_POS_Y = 5'd2;
  localparam logic [RA_W-1:0] F_MOM_Y = 5'd3, F_EDEV = 5'd4,  F_PATH = 5'd5;

  localparam logic [PC_W-1:0] PC_LOOP = 7'd13;
  localparam logic [PC_W-1:0] PC_POST = 7'd27;

  typedef struct packed {
    logic                    mode;
    logic [3:0]              coef_index;
    logic signed [63:0]      coef_skew;
    logic signed [63:0]      coef_normal;
    logic signed [CW-1:0]    pos_x;
    logic signed [CW-1:0]    mom_x;
    logic signed [CW-1:0]    pos_y;
    logic signed [CW-1:0]    mom_y;
    logic signed [CW-1:0]    energy_dev;
    logic signed [CW-1:0]    path_len;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] new_pos_x;
    logic signed [CW-1:0] new_mom_x;
    logic signed [CW-1:0] new_pos_y;
    logic signed [CW-1:0] new_mom_y;
    logic signed [CW-1:0] new_energy_dev;
    logic signed [CW-1:0] new_path_len;
  } out_item_t;

  typedef struct packed {
    logic [4:0]      op;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] a;
    logic [RA_W-1:0] b;
    logic [PC_W-1:0] tgt;
  } instr_t;

  typedef struct packed {
    logic              start;
    logic              out_set;
    logic [4:0]        op;
    logic [RA_W-1:0]   dst;
    logic [RA_W-1:0]   a;
    logic [RA_W-1:0]   b;
    logic [OIDX_W-1:0] cidx;
  } cmd_t;

  typedef struct packed {
    logic              done;
    logic              out_full;
    logic [OIDX_W-1:0] max_order;
  } stat_t;

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m);
    if (!neg) return m[63] ? S64_MAX : m;
    if (m > {1'b1, 63'd0}) return S64_MIN;
    return ~m + 64'd1;
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(logic signed [63:0] v);
    if (v[63:CW-1] != {(65-CW){v[63]}}) return v[63] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    return v[CW-1:0];
  endfunction

  function automatic instr_t mk(logic [4:0] op, logic [RA_W-1:0] dst, logic [RA_W-1:0] a,
                                logic [RA_W-1:0] b, logic [PC_W-1:0] tgt);
    instr_t i;
    i.op = op; i.dst = dst; i.a = a; i.b = b; i.tgt = tgt;
    return i;
  endfunction

  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      7'd0:  i = mk(OP_LDIN, R_X, R_X, R_X, '0);
      7'd1:  i = mk(OP_LDIN, R_PX, R_PX, R_X, '0);
      7'd2:  i = mk(OP_LDIN, R_Y, R_Y, R_X, '0);
      7'd3:  i = mk(OP_LDIN, R_PY, R_PY, R_X, '0);
      7'd4:  i = mk(OP_LDIN, R_DP, R_DP, R_X, '0);
      7'd5:  i = mk(OP_LDIN, R_Z, R_Z, R_X, '0);
      7'd6:  i = mk(OP_LDIN, R_L, R_L, R_X, '0);
      7'd7:  i = mk(OP_LDIN, R_IRHO, R_IRHO, R_X, '0);
      7'd8:  i = mk(OP_LDIN, R_RC, R_RC, R_X, '0);
      7'd9:  i = mk(OP_LDIN, R_ONE, R_ONE, R_X, '0);
      7'd10: i = mk(OP_SETC, R_X, R_X, R_X, '0);
      7'd11: i = mk(OP_LDCN, R_RE, R_X, R_X, '0);
      7'd12: i = mk(OP_LDCS, R_IM, R_X, R_X, '0);
      7'd13: i = mk(OP_BRZ, R_X, R_X, R_X, PC_POST);
      7'd14: i = mk(OP_DEC, R_X, R_X, R_X, '0);
      7'd15: i = mk(OP_MUL, R_T0, R_RE, R_X, '0);
      7'd16: i = mk(OP_MUL, R_T1, R_IM, R_Y, '0);
      7'd17: i = mk(OP_SUB, R_T0, R_T0, R_T1, '0);
      7'd18: i = mk(OP_LDCN, R_T1, R_X, R_X, '0);
      7'd19: i = mk(OP_ADD, R_T2, R_T0, R_T1, '0);
      7'd20: i = mk(OP_MUL, R_T0, R_IM, R_X, '0);
      7'd21: i = mk(OP_MUL, R_T1, R_RE, R_Y, '0);
      7'd22: i = mk(OP_ADD, R_T0, R_T0, R_T1, '0);
      7'd23: i = mk(OP_LDCS, R_T1, R_X, R_X, '0);
      7'd24: i = mk(OP_ADD, R_IM, R_T0, R_T1, '0);
      7'd25: i = mk(OP_MOV, R_RE, R_T2, R_X, '0);
      7'd26: i = mk(OP_JMP, R_X, R_X, R_X, PC_LOOP);
      7'd27: i = mk(OP_ADD, R_OPD, R_ONE, R_DP, '0);
      7'd28: i = mk(OP_DIV, R_XPR, R_PX, R_OPD, '0);
      7'd29: i = mk(OP_DIV, R_YPR, R_PY, R_OPD, '0);
      7'd30: i = mk(OP_MUL, R_XR, R_X, R_IRHO, '0);
      7'd31: i = mk(OP_ADD, R_H, R_ONE, R_XR, '0);
      7'd32: i = mk(OP_ADD, R_BY, R_RE, R_IRHO, '0);
      7'd33: i = mk(OP_MUL, R_T0, R_XPR, R_XPR, '0);
      7'd34: i = mk(OP_MUL, R_T1, R_YPR, R_YPR, '0);
      7'd35: i = mk(OP_ADD, R_ANG2, R_T0, R_T1, '0);
      7'd36: i = mk(OP_MUL, R_T0, R_H, R_H, '0);
      7'd37: i = mk(OP_ADD, R_DEN, R_T0, R_ANG2, '0);
      7'd38: i = mk(OP_MUL, R_T1, R_BY, R_H, '0);
      7'd39: i = mk(OP_MUL, R_T2, R_IM, R_H, '0);
      7'd40: i = mk(OP_MUL, R_T0, R_IM, R_YPR, '0);
      7'd41: i = mk(OP_MUL, R_T3, R_BY, R_XPR, '0);
      7'd42: i = mk(OP_SUB, R_T3, R_T0, R_T3, '0);
      7'd43: i = mk(OP_MUL, R_T0, R_T1, R_T1, '0);
      7'd44: i = mk(OP_MUL, R_T2, R_T2, R_T2, '0);
      7'd45: i = mk(OP_ADD, R_T0, R_T0, R_T2, '0);
      7'd46: i = mk(OP_MUL, R_T3, R_T3, R_T3, '0);
      7'd47: i = mk(OP_ADD, R_NUM, R_T0, R_T3, '0);
      7'd48: i = mk(OP_DIV, R_B2P, R_NUM, R_DEN, '0);
      7'd49: i = mk(OP_SHR, R_T0, R_ANG2, R_X, '0);
      7'd50: i = mk(OP_ADD, R_FAC, R_H, R_T0, '0);
      7'd51: i = mk(OP_MUL, R_T0, R_OPD, R_OPD, '0);
      7'd52: i = mk(OP_MUL, R_FAC, R_FAC, R_T0, '0);
      7'd53: i = mk(OP_MUL, R_FAC, R_FAC, R_L, '0);
      7'd54: i = mk(OP_MULRC, R_T0, R_RC, R_B2P, '0);
      7'd55: i = mk(OP_MUL, R_LOSS, R_T0, R_FAC, '0);
      7'd56: i = mk(OP_SUB, R_DPN, R_DP, R_LOSS, '0);
      7'd57: i = mk(OP_ADD, R_OPDN, R_ONE, R_DPN, '0);
      7'd58: i = mk(OP_MUL, R_PXN, R_XPR, R_OPDN, '0);
      7'd59: i = mk(OP_MUL, R_PYN, R_YPR, R_OPDN, '0);
      7'd60: i = mk(OP_SUB, R_T0, R_DP, R_XR, '0);
      7'd61: i = mk(OP_MUL, R_T1, R_T0, R_IRHO, '0);
      7'd62: i = mk(OP_SUB, R_T0, R_RE, R_T1, '0);
      7'd63: i = mk(OP_MUL, R_T0, R_L, R_T0, '0);
      7'd64: i = mk(OP_SUB, R_PXN, R_PXN, R_T0, '0);
      7'd65: i = mk(OP_MUL, R_T0, R_L, R_IM, '0);
      7'd66: i = mk(OP_ADD, R_PYN, R_PYN, R_T0, '0);
      7'd67: i = mk(OP_MUL, R_T0, R_L, R_IRHO, '0);
      7'd68: i = mk(OP_MUL, R_T0, R_T0, R_X, '0);
      7'd69: i = mk(OP_ADD, R_Z, R_Z, R_T0, '0);
      7'd70: i = mk(OP_WOUT, R_X, R_X, R_X, '0);
      7'd71: i = mk(OP_STO, F_POS_X, R_X, R_X, '0);
      7'd72: i = mk(OP_STO, F_MOM_X, R_PXN, R_X, '0);
      7'd73: i = mk(OP_STO, F_POS_Y, R_Y, R_X, '0);
      7'd74: i = mk(OP_STO, F_MOM_Y, R_PYN, R_X, '0);
      7'd75: i = mk(OP_STO, F_EDEV, R_DPN, R_X, '0);
      7'd76: i = mk(OP_STO, F_PATH, R_Z, R_X, '0);
      default: i = mk(OP_END, R_X, R_X, R_X, '0);
    endcase
    return i;
  endfunction

endpackage

// ----- design/bmrk_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on bmrk_pkg for the payload types.
interface bmrk_in_if import bmrk_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmrk_out_if import bmrk_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/bend_multipole_radiation_kick_unit.sv -----
// Top level of the bend multipole radiation kick unit: channels, config port,
// controller and datapath. Depends on bmrk_pkg, bmrk_ifs, bmrk_ctrl, bmrk_datapath.
//
//   channel      dir  handshake      beat
//   item_in      in   valid/ready    one load or track item
//   result_out   out  valid/ready    six result coordinates
//   cfg_*        in   write enable   one register write
//
// A track item's run time grows with the configured max_order, which sets the
// number of coefficient loop passes; all products go through the shared
// multiplier and the three quotients through the bit-serial divider.
// Reset is synchronous; the coefficient store reads as zero until loaded.
// A result waits in the output register; the next item is accepted meanwhile
// and the sequencer holds before writing its own result until that beat leaves.
module bend_multipole_radiation_kick_unit import bmrk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bmrk_in_if.sink     item_in,
  bmrk_out_if.source  result_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;
  logic  idle, in_fire, out_fire, out_valid;

  assign item_in.ready    = idle;
  assign in_fire          = item_in.valid && idle;
  assign out_fire         = out_valid && result_out.ready;
  assign result_out.valid = out_valid;

  bmrk_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_mode (item_in.data.mode),
    .idle    (idle),
    .cmd     (cmd),
    .st      (st)
  );

  bmrk_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_data   (item_in.data),
    .out_fire  (out_fire),
    .out_data  (result_out.data),
    .out_valid (out_valid),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- design/bmrk_datapath.sv -----
// Datapath: config registers, coefficient store, register file, shared
// multiplier and divider, output register. Depends on bmrk_pkg.
module bmrk_datapath import bmrk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [62:0] cfg_data,
  input  logic       in_fire,
  input  in_item_t   in_data,
  input  logic       out_fire,
  output out_item_t  out_data,
  output logic       out_valid,
  input  cmd_t       cmd,
  output stat_t      st
);

  logic [OIDX_W-1:0] max_order;
  logic [46:0]       elen;
  logic signed [47:0] irho;
  logic [62:0]       rconst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_order <= '0;
      elen      <= '0;
      irho      <= '0;
      rconst    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ORDER: max_order <= cfg_data[OIDX_W-1:0];
        CFG_LENGTH:    elen      <= cfg_data[46:0];
        CFG_IRHO:      irho      <= cfg_data[47:0];
        CFG_RAD:       rconst    <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient store; an entry never loaded reads as zero
  logic signed [63:0] normal_mem [ODEPTH];
  logic signed [63:0] skew_mem   [ODEPTH];
  logic [ODEPTH-1:0]  cvalid;
  logic signed [63:0] cn_q, cs_q;
  logic               load_we;

  assign load_we = in_fire && !in_data.mode;

  always_ff @(posedge clk) begin
    if (rst) cvalid <= '0;
    else if (load_we) cvalid[in_data.coef_index[OIDX_W-1:0]] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      normal_mem[in_data.coef_index[OIDX_W-1:0]] <= in_data.coef_normal;
      skew_mem[in_data.coef_index[OIDX_W-1:0]]   <= in_data.coef_skew;
    end
    cn_q <= cvalid[cmd.cidx] ? normal_mem[cmd.cidx] : 64'sd0;
    cs_q <= cvalid[cmd.cidx] ? skew_mem[cmd.cidx] : 64'sd0;
  end

  in_item_t item;
  always_ff @(posedge clk) begin
    if (in_fire && in_data.mode) item <= in_data;
  end

  // register file, two registered read ports
  logic signed [63:0] rf [1 << RA_W];
  logic signed [63:0] ra_q, rb_q, res;
  logic               rf_we;

  always_ff @(posedge clk) begin
    if (rf_we) rf[cmd.dst] <= res;
    ra_q <= rf[cmd.a];
    rb_q <= rf[cmd.b];
  end

  // shared multiplier: four 32x32 partial products, then round and saturate
  logic [63:0]  ma, mb;
  logic         mneg, msh60, mbusy;
  logic [2:0]   mstep;
  logic [63:0]  p_q;
  logic [1:0]   pq_sh;
  logic [127:0] acc, rnd, rsh;
  logic         mul_done;
  logic signed [63:0] mul_res;
  logic [31:0]  pa, pb;

  assign pa = mstep[0] ? ma[63:32] : ma[31:0];
  assign pb = mstep[1] ? mb[63:32] : mb[31:0];
  assign mul_done = mbusy && (mstep == 3'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mstep <= '0;
    end else if (cmd.start && (cmd.op == OP_MUL || cmd.op == OP_MULRC)) begin
      mbusy <= 1'b1;
      mstep <= '0;
    end else if (mbusy) begin
      mstep <= mstep + 3'd1;
      if (mstep == 3'd5) mbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ma    <= mag(ra_q);
      mb    <= mag(rb_q);
      mneg  <= ra_q[63] ^ rb_q[63];
      msh60 <= (cmd.op == OP_MULRC);
      acc   <= '0;
    end else if (mbusy) begin
      if (mstep < 3'd4) begin
        p_q   <= pa * pb;
        pq_sh <= {1'b0, mstep[0]} + {1'b0, mstep[1]};
      end
      if (mstep >= 3'd1 && mstep <= 3'd4) acc <= acc + ({64'd0, p_q} << (7'd32 * pq_sh));
    end
  end

  always_comb begin
    rnd = acc + (msh60 ? (128'd1 << (RC_FRAC - 1)) : (128'd1 << (FRAC - 1)));
    rsh = msh60 ? (rnd >> RC_FRAC) : (rnd >> FRAC);
    if (rsh[127:64] != '0) mul_res = mneg ? S64_MIN : S64_MAX;
    else mul_res = from_mag(mneg, rsh[63:0]);
  end

  // shared restoring divider, one quotient bit per cycle
  logic [63:0]        dmb, dr, dq;
  logic [64+FRAC-1:0] nreg;
  logic [DCNT_W-1:0]  dcnt;
  logic               dbusy, dneg, dover, div_done, div_zero;
  logic [64:0]        r2, rdiff;
  logic               ge;
  logic signed [63:0] div_res;

  assign div_zero = cmd.start && (cmd.op == OP_DIV) && (rb_q == 64'sd0);
  assign div_done = dbusy && (dcnt == DCNT_W'(DIV_STEPS));
  assign r2       = {dr, nreg[64+FRAC-1]};
  assign rdiff    = r2 - {1'b0, dmb};
  assign ge       = (r2 >= {1'b0, dmb});
  assign div_res  = dover ? (dneg ? S64_MIN : S64_MAX) : from_mag(dneg, dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (cmd.start && cmd.op == OP_DIV && !div_zero) begin
      dbusy <= 1'b1;
      dcnt  <= '0;
    end else if (dbusy) begin
      if (div_done) dbusy <= 1'b0;
      else dcnt <= dcnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nreg  <= {mag(ra_q), {FRAC{1'b0}}};
      dmb   <= mag(rb_q);
      dneg  <= ra_q[63] ^ rb_q[63];
      dr    <= '0;
      dq    <= '0;
      dover <= 1'b0;
    end else if (dbusy && !div_done) begin
      dr   <= ge ? rdiff[63:0] : r2[63:0];
      dq   <= {dq[62:0], ge};
      nreg <= nreg << 1;
      // a quotient bit above bit 63 means overflow
      if (ge && dcnt < DCNT_W'(FRAC)) dover <= 1'b1;
    end
  end

  // operations that finish in the same cycle as their start
  logic signed [63:0] simple_res;
  logic               is_simple;

  assign is_simple = cmd.op inside {OP_LDIN, OP_LDCN, OP_LDCS, OP_ADD, OP_SUB,
                                    OP_MOV, OP_SHR, OP_STO};

  always_comb begin
    case (cmd.op)
      OP_LDIN: begin
        case (cmd.a)
          R_X:     simple_res = 64'(item.pos_x);
          R_PX:    simple_res = 64'(item.mom_x);
          R_Y:     simple_res = 64'(item.pos_y);
          R_PY:    simple_res = 64'(item.mom_y);
          R_DP:    simple_res = 64'(item.energy_dev);
          R_Z:     simple_res = 64'(item.path_len);
          R_L:     simple_res = {17'd0, elen};
          R_IRHO:  simple_res = 64'(irho);
          R_RC:    simple_res = {1'b0, rconst};
          R_ONE:   simple_res = ONE_Q;
          default: simple_res = '0;
        endcase
      end
      OP_LDCN: simple_res = cn_q;
      OP_LDCS: simple_res = cs_q;
      OP_ADD:  simple_res = sadd(ra_q, rb_q);
      OP_SUB:  simple_res = ssub(ra_q, rb_q);
      OP_MOV:  simple_res = ra_q;
      OP_SHR:  simple_res = ra_q >>> 1;
      default: simple_res = ra_q;
    endcase
  end

  logic done;
  assign done = (cmd.start && (is_simple || div_zero)) || mul_done || div_done;

  always_comb begin
    if (mul_done) res = mul_res;
    else if (div_done) res = div_res;
    else if (div_zero) res = (ra_q == 64'sd0) ? 64'sd0 : (ra_q[63] ? S64_MIN : S64_MAX);
    else res = simple_res;
  end

  assign rf_we = done && (cmd.op != OP_STO);

  // output register
  always_ff @(posedge clk) begin
    if (done && cmd.op == OP_STO) begin
      case (cmd.dst)
        F_POS_X: out_data.new_pos_x      <= sat_coord(ra_q);
        F_MOM_X: out_data.new_mom_x      <= sat_coord(ra_q);
        F_POS_Y: out_data.new_pos_y      <= sat_coord(ra_q);
        F_MOM_Y: out_data.new_mom_y      <= sat_coord(ra_q);
        F_EDEV:  out_data.new_energy_dev <= sat_coord(ra_q);
        F_PATH:  out_data.new_path_len   <= sat_coord(ra_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_set) out_valid <= 1'b1;
    else if (out_fire) out_valid <= 1'b0;
  end

  assign st.done      = done;
  assign st.out_full  = out_valid;
  assign st.max_order = max_order;

endmodule

// ----- design/bmrk_ctrl.sv -----
// Controller: microcode sequencer that steps the program held in the
// package and drives the datapath. Depends on bmrk_pkg.
module bmrk_ctrl import bmrk_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  in_mode,
  output logic  idle,
  output cmd_t  cmd,
  input  stat_t st
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_START = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]        state, state_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic [OIDX_W-1:0] cnt, cnt_next;
  instr_t            instr;
  logic              out_set;

  assign instr = prog(pc);
  assign idle  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cnt_next   = cnt;
    out_set    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire && in_mode) begin
          pc_next    = '0;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (instr.op)
          OP_SETC: begin
            cnt_next = st.max_order;
            pc_next  = pc + PC_W'(1);
          end
          OP_BRZ:  pc_next = (cnt == '0) ? instr.tgt : pc + PC_W'(1);
          OP_DEC: begin
            cnt_next = cnt - OIDX_W'(1);
            pc_next  = pc + PC_W'(1);
          end
          OP_JMP:  pc_next = instr.tgt;
          // hold until the previous result has left
          OP_WOUT: if (!st.out_full) pc_next = pc + PC_W'(1);
          OP_END: begin
            out_set    = 1'b1;
            cnt_next   = '0;
            state_next = S_IDLE;
          end
          default: state_next = S_START;
        endcase
      end
      S_START, S_WAIT: begin
        if (st.done) begin
          pc_next    = pc + PC_W'(1);
          state_next = S_ISSUE;
        end else begin
          state_next = S_WAIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      cnt   <= cnt_next;
    end
  end

  assign cmd.start   = (state == S_START);
  assign cmd.out_set = out_set;
  assign cmd.op      = instr.op;
  assign cmd.dst     = instr.dst;
  assign cmd.a       = instr.a;
  assign cmd.b       = instr.b;
  assign cmd.cidx    = cnt;

`ifndef SYNTHESIS
  a_done_when_running: assert property (@(posedge clk) disable iff (rst)
    st.done |-> (state == S_START || state == S_WAIT))
    else $error("datapath done outside an arithmetic step");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_set |-> !st.out_full)
    else $error("result posted while output register still full");

  a_order_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (cnt <= st.max_order))
    else $error("order counter beyond configured order");

  a_idle_after_end: assert property (@(posedge clk) disable iff (rst)
    cmd.out_set |=> (state == S_IDLE))
    else $error("sequencer kept running after posting a result");
`endif

endmodule
